/* rtl/core/bti_pkg.sv */
package bti_pkg;

  localparam int BTI_TABLE_DEPTH = 65536;
  localparam int BTI_LATENCY     = 55;
  localparam int EXP_TERMS       = 12;

  typedef enum logic [2:0] {
    CFG_A_ORIGIN  = 3'd0,
    CFG_B_ORIGIN  = 3'd1,
    CFG_A_SPACING = 3'd2,
    CFG_B_SPACING = 3'd3,
    CFG_A_RECIP   = 3'd4,
    CFG_B_RECIP   = 3'd5,
    CFG_ROWS      = 3'd6,
    CFG_COLS      = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [15:0]        entry_index;
    logic signed [23:0] entry_value;
    logic signed [23:0] coord_a;
    logic signed [23:0] coord_b;
  } in_item_t;

  typedef struct packed {
    logic [47:0] value;
    logic        clamped_low;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic query;
    logic clamped;
  } ctl_t;

  localparam logic signed [23:0] A_ORIGIN_RST = -24'sd603607;
  localparam logic signed [23:0] B_ORIGIN_RST = 24'sd53178;
  localparam logic [22:0]        A_SPACING_RST = 23'd6554;
  localparam logic [22:0]        B_SPACING_RST = 23'd1311;
  localparam logic [23:0]        A_RECIP_RST   = 24'd655360;
  localparam logic [23:0]        B_RECIP_RST   = 24'd3276800;
  localparam logic [8:0]         ROWS_RST      = 9'd113;
  localparam logic [8:0]         COLS_RST      = 9'd225;

  localparam logic [47:0]        OUT_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [49:0] EXP_X_HI  = 50'sd1114112;
  localparam logic signed [49:0] EXP_X_LO  = -50'sd1179648;
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;

endpackage

/* rtl/core/bti_ram.sv */
module bti_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = bti_pkg::BTI_TABLE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr0,
  input  logic [AW-1:0]    rd_addr1,
  output logic [WIDTH-1:0] rd_data0_r,
  output logic [WIDTH-1:0] rd_data1_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0_r <= mem[rd_addr0];
    rd_data1_r <= mem[rd_addr1];
  end

endmodule

/* rtl/core/bti_axis.sv */
module bti_axis (
  input  logic               clk,
  input  logic signed [23:0] coord,
  input  logic signed [23:0] org,
  input  logic [22:0]        spacing,
  input  logic [23:0]        recip,
  input  logic [8:0]         cnt,
  output logic [7:0]         lo_r,
  output logic               d2_r,
  output logic               clamped_r,
  output logic signed [31:0] weight_r
);

  localparam logic signed [56:0] W_HI = 57'sd1073741824;
  localparam logic signed [56:0] W_LO = -57'sd1073741824;

  logic signed [24:0] diff1_r, diff2_r, diff3_r;
  logic signed [49:0] p2_r;
  logic signed [31:0] ta4_r;
  logic               d2_4_r, d2_5_r;
  logic signed [56:0] prod5_r;

  logic [49:0] mag;
  logic [17:0] iq;
  logic [7:0]  last;
  logic        below;
  logic [7:0]  hi;
  logic        d2;
  logic [30:0] lsp;
  logic signed [56:0] sh;
  logic signed [31:0] w;

  always_comb begin
    mag   = p2_r[49] ? 50'(-p2_r) : 50'(p2_r);
    iq    = p2_r[49] ? 18'd0 : mag[49:32];
    last  = 8'(cnt - 9'd1);
    below = iq < {10'd0, last};
    hi    = below ? 8'(iq[7:0] + 8'd1) : last;
    d2    = !below && (cnt >= 9'd3);
  end

  assign lsp = 31'(lo_r * spacing);

  always_comb begin
    sh = d2_5_r ? (prod5_r >>> 17) : (prod5_r >>> 16);
    if (sh > W_HI) begin
      w = W_HI[31:0];
    end else if (sh < W_LO) begin
      w = W_LO[31:0];
    end else begin
      w = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    diff1_r   <= 25'(coord) - 25'(org);
    p2_r      <= diff1_r * $signed({1'b0, recip});
    diff2_r   <= diff1_r;
    lo_r      <= 8'(hi - (d2 ? 8'd2 : 8'd1));
    d2_r      <= d2;
    clamped_r <= p2_r[49] && (mag[49:32] != 18'd0);
    diff3_r   <= diff2_r;
    ta4_r     <= 32'(diff3_r) - $signed({1'b0, lsp});
    d2_4_r    <= d2_r;
    prod5_r   <= ta4_r * $signed({1'b0, recip});
    d2_5_r    <= d2_4_r;
    weight_r  <= w;
  end

endmodule

/* rtl/core/bti_exp.sv */
module bti_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  bti_pkg::ctl_t      ctl_i,
  input  logic signed [49:0] x_i,
  output logic               out_strobe_r,
  output bti_pkg::out_item_t out_item_r
);

  import bti_pkg::*;

  localparam int NST = 3 * EXP_TERMS;

  typedef struct packed {
    ctl_t               ctl;
    logic               sat_e;
    logic               zero_e;
    logic signed [7:0]  k;
    logic [29:0]        z;
  } pass_t;

  ctl_t               ctl1_r, ctl2_r;
  logic               sat1_r, zero1_r, sat2_r, zero2_r;
  logic signed [21:0] xs1_r;
  logic signed [53:0] y2_r;
  logic [59:0]        zp;

  pass_t       pass_r [0:NST];
  logic [30:0] t_r    [0:EXP_TERMS];
  logic [31:0] sum_r  [0:EXP_TERMS];
  logic [30:0] qa_r   [1:EXP_TERMS];
  logic [30:0] qb_r   [1:EXP_TERMS];
  logic [30:0] qh_r   [1:EXP_TERMS];
  logic [31:0] suma_r [1:EXP_TERMS];
  logic [31:0] sumb_r [1:EXP_TERMS];

  pass_t       passf_r;
  logic [63:0] v_r;
  logic [63:0] v;
  logic        sat;

  assign zp = y2_r[45:16] * LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r    <= '0;
      ctl2_r    <= '0;
      pass_r[0] <= '0;
    end else begin
      ctl1_r           <= ctl_i;
      ctl2_r           <= ctl1_r;
      pass_r[0].ctl    <= ctl2_r;
      pass_r[0].sat_e  <= sat2_r;
      pass_r[0].zero_e <= zero2_r;
      pass_r[0].k      <= y2_r[53:46];
      pass_r[0].z      <= zp[59:30];
    end
  end

  always_ff @(posedge clk) begin
    sat1_r   <= x_i > EXP_X_HI;
    zero1_r  <= x_i < EXP_X_LO;
    xs1_r    <= x_i[21:0];
    y2_r     <= xs1_r * LOG2E_Q30;
    sat2_r   <= sat1_r;
    zero2_r  <= zero1_r;
    t_r[0]   <= 31'h4000_0000;
    sum_r[0] <= 32'h4000_0000;
  end

  for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_term
    localparam int          N     = n;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
    localparam logic [3:0]  NV    = 4'(N);

    logic [60:0] tz;
    logic [63:0] qm;
    logic [30:0] rem;
    logic [30:0] tq;

    assign tz  = t_r[n-1] * pass_r[3*n-3].z;
    assign qm  = qa_r[n] * RECIP;
    assign rem = 31'(qb_r[n] - qh_r[n] * NV);
    assign tq  = (rem >= 31'(NV)) ? 31'(qh_r[n] + 31'd1) : qh_r[n];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pass_r[3*n-2] <= '0;
        pass_r[3*n-1] <= '0;
        pass_r[3*n]   <= '0;
      end else begin
        pass_r[3*n-2] <= pass_r[3*n-3];
        pass_r[3*n-1] <= pass_r[3*n-2];
        pass_r[3*n]   <= pass_r[3*n-1];
      end
    end

    always_ff @(posedge clk) begin
      qa_r[n]   <= tz[60:30];
      suma_r[n] <= sum_r[n-1];
      qh_r[n]   <= qm[62:32];
      qb_r[n]   <= qa_r[n];
      sumb_r[n] <= suma_r[n];
      t_r[n]    <= tq;
      sum_r[n]  <= sumb_r[n] + 32'(tq);
    end
  end

  always_comb begin
    if (pass_r[NST].k >= 8'sd6) begin
      v = 64'(sum_r[EXP_TERMS]) << 8'(pass_r[NST].k - 8'sd6);
    end else begin
      v = 64'(sum_r[EXP_TERMS]) >> 8'(8'sd6 - pass_r[NST].k);
    end
  end

  assign sat = passf_r.sat_e || (!passf_r.zero_e && (v_r[63:48] != 16'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passf_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      passf_r      <= pass_r[NST];
      out_strobe_r <= passf_r.ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    v_r                    <= v;
    out_item_r.clamped_low <= passf_r.ctl.clamped;
    out_item_r.saturated   <= passf_r.ctl.query && sat;
    if (!passf_r.ctl.query || (!sat && passf_r.zero_e)) begin
      out_item_r.value <= 48'd0;
    end else if (sat) begin
      out_item_r.value <= OUT_MAX;
    end else begin
      out_item_r.value <= v_r[47:0];
    end
  end

endmodule

/* rtl/core/bilinear_table_interp_exp.sv */
// channel   ports                            accepted when
// input     start, busy, in_item             start && !busy
// result    out_strobe, out_item             out_strobe (one cycle, no hold-off)
// config    cfg_we, cfg_index, cfg_data      cfg_we
//
// One item per cycle; busy stays low. Each result passes through the 14-stage lookup and
// interpolation pipeline and then the 41-stage exp unit
// (12 series terms of three stages each).
// Table reads and load writes share one pipeline stage, so a query sees every earlier load.
// Reset clears the control pipeline and restores the config defaults, not the table.
module bilinear_table_interp_exp #(
  parameter int TABLE_DEPTH = bti_pkg::BTI_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bti_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output bti_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  import bti_pkg::*;

  localparam int          AW         = $clog2(TABLE_DEPTH);
  localparam logic [32:0] ADDR_RECIP = 33'((64'd1 << 32) / TABLE_DEPTH);
  localparam logic [17:0] DEPTH_V    = 18'(TABLE_DEPTH);
  localparam logic signed [56:0] I32_HI = 57'sd2147483647;
  localparam logic signed [56:0] I32_LO = -57'sd2147483648;

  logic signed [23:0] a_origin_r, b_origin_r;
  logic [22:0]        a_spacing_r, b_spacing_r;
  logic [23:0]        a_recip_r, b_recip_r;
  logic [8:0]         rows_r, cols_r;
  logic [8:0]         nr, nc;

  logic      accept;
  logic      v0_r;
  in_item_t  in0_r;
  ctl_t      ctl_r [1:13];

  logic [15:0] wr_idx_r [1:6];
  logic [23:0] wr_val_r [1:6];

  logic [7:0]         lo_a, lo_b;
  logic               d2_a, d2_b, clamp_a, clamp_b;
  logic signed [31:0] w_a, w_b;

  logic [16:0] rowa4_r, rowb4_r;
  logic [8:0]  cola4_r, colb4_r;
  logic [16:0] lin5_r [4];
  logic [16:0] lin6_r [4];
  logic [16:0] qh6_r  [4];
  logic [AW-1:0] raddr [4];
  logic [23:0]   rd    [4];
  logic          wr_en;

  logic signed [31:0] wa7_r, wa8_r;
  logic signed [31:0] wb_r [7:11];
  logic signed [23:0] f00_8_r, f01_8_r, f00_9_r, f01_9_r;
  logic signed [24:0] df0_8_r, df1_8_r;
  logic signed [56:0] m0_9_r, m1_9_r;
  logic signed [56:0] s0, s1;
  logic signed [31:0] fa0_10_r, fa1_10_r, fa0_11_r, fa0_12_r;
  logic signed [32:0] dfb_11_r;
  logic signed [64:0] mb_12_r;
  logic signed [64:0] fsum;
  logic signed [49:0] fab_13_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign nr = (rows_r < 9'd2) ? 9'd2 : (rows_r > 9'd256) ? 9'd256 : rows_r;
  assign nc = (cols_r < 9'd2) ? 9'd2 : (cols_r > 9'd256) ? 9'd256 : cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_origin_r  <= A_ORIGIN_RST;
      b_origin_r  <= B_ORIGIN_RST;
      a_spacing_r <= A_SPACING_RST;
      b_spacing_r <= B_SPACING_RST;
      a_recip_r   <= A_RECIP_RST;
      b_recip_r   <= B_RECIP_RST;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_A_ORIGIN:  a_origin_r  <= cfg_data;
        CFG_B_ORIGIN:  b_origin_r  <= cfg_data;
        CFG_A_SPACING: a_spacing_r <= cfg_data[22:0];
        CFG_B_SPACING: b_spacing_r <= cfg_data[22:0];
        CFG_A_RECIP:   a_recip_r   <= cfg_data;
        CFG_B_RECIP:   b_recip_r   <= cfg_data;
        CFG_ROWS:      rows_r      <= cfg_data[8:0];
        CFG_COLS:      cols_r      <= cfg_data[8:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int s = 1; s <= 13; s++) begin
        ctl_r[s] <= '0;
      end
    end else begin
      v0_r           <= accept;
      ctl_r[1].vld   <= v0_r;
      ctl_r[1].query <= in0_r.operation == OP_QUERY;
      ctl_r[1].clamped <= 1'b0;
      for (int s = 2; s <= 13; s++) begin
        if (s != 4) begin
          ctl_r[s] <= ctl_r[s-1];
        end
      end
      ctl_r[4].vld     <= ctl_r[3].vld;
      ctl_r[4].query   <= ctl_r[3].query;
      ctl_r[4].clamped <= ctl_r[3].query && (clamp_a || clamp_b);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in0_r <= in_item;
    end
    wr_idx_r[1] <= in0_r.entry_index;
    wr_val_r[1] <= in0_r.entry_value;
    for (int s = 2; s <= 6; s++) begin
      wr_idx_r[s] <= wr_idx_r[s-1];
      wr_val_r[s] <= wr_val_r[s-1];
    end
  end

  bti_axis u_axis_a (
    .clk       (clk),
    .coord     (in0_r.coord_a),
    .org       (a_origin_r),
    .spacing   (a_spacing_r),
    .recip     (a_recip_r),
    .cnt       (nr),
    .lo_r      (lo_a),
    .d2_r      (d2_a),
    .clamped_r (clamp_a),
    .weight_r  (w_a)
  );

  bti_axis u_axis_b (
    .clk       (clk),
    .coord     (in0_r.coord_b),
    .org       (b_origin_r),
    .spacing   (b_spacing_r),
    .recip     (b_recip_r),
    .cnt       (nc),
    .lo_r      (lo_b),
    .d2_r      (d2_b),
    .clamped_r (clamp_b),
    .weight_r  (w_b)
  );

  always_ff @(posedge clk) begin
    rowa4_r <= 17'(lo_a * nc);
    rowb4_r <= 17'(8'(lo_a + (d2_a ? 8'd2 : 8'd1)) * nc);
    cola4_r <= {1'b0, lo_b};
    colb4_r <= 9'(lo_b + (d2_b ? 8'd2 : 8'd1));
    lin5_r[0] <= rowa4_r + 17'(cola4_r);
    lin5_r[1] <= rowa4_r + 17'(colb4_r);
    lin5_r[2] <= rowb4_r + 17'(cola4_r);
    lin5_r[3] <= rowb4_r + 17'(colb4_r);
    for (int j = 0; j < 4; j++) begin
      lin6_r[j] <= lin5_r[j];
      qh6_r[j]  <= 17'((50'(lin5_r[j]) * 50'(ADDR_RECIP)) >> 32);
    end
  end

  always_comb begin
    logic [17:0] rem;
    for (int j = 0; j < 4; j++) begin
      rem = {1'b0, lin6_r[j]} - 18'(qh6_r[j] * DEPTH_V);
      if (rem >= DEPTH_V) begin
        rem = rem - DEPTH_V;
      end
      raddr[j] = rem[AW-1:0];
    end
  end

  assign wr_en = ctl_r[6].vld && !ctl_r[6].query
              && ({1'b0, wr_idx_r[6]} < 17'(TABLE_DEPTH));

  bti_ram #(.WIDTH(24), .DEPTH(TABLE_DEPTH)) u_ram_lo (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_idx_r[6][AW-1:0]),
    .wr_data    (wr_val_r[6]),
    .rd_addr0   (raddr[0]),
    .rd_addr1   (raddr[1]),
    .rd_data0_r (rd[0]),
    .rd_data1_r (rd[1])
  );

  bti_ram #(.WIDTH(24), .DEPTH(TABLE_DEPTH)) u_ram_hi (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_idx_r[6][AW-1:0]),
    .wr_data    (wr_val_r[6]),
    .rd_addr0   (raddr[2]),
    .rd_addr1   (raddr[3]),
    .rd_data0_r (rd[2]),
    .rd_data1_r (rd[3])
  );

  always_comb begin
    s0   = 57'(f00_9_r) + (m0_9_r >>> 16);
    s1   = 57'(f01_9_r) + (m1_9_r >>> 16);
    fsum = 65'(fa0_12_r) + (mb_12_r >>> 16);
  end

  always_ff @(posedge clk) begin
    wa7_r    <= w_a;
    wa8_r    <= wa7_r;
    wb_r[7]  <= w_b;
    for (int s = 8; s <= 11; s++) begin
      wb_r[s] <= wb_r[s-1];
    end
    f00_8_r  <= $signed(rd[0]);
    f01_8_r  <= $signed(rd[1]);
    df0_8_r  <= 25'($signed(rd[2])) - 25'($signed(rd[0]));
    df1_8_r  <= 25'($signed(rd[3])) - 25'($signed(rd[1]));
    m0_9_r   <= wa8_r * df0_8_r;
    m1_9_r   <= wa8_r * df1_8_r;
    f00_9_r  <= f00_8_r;
    f01_9_r  <= f01_8_r;
    fa0_10_r <= (s0 > I32_HI) ? I32_HI[31:0] : (s0 < I32_LO) ? I32_LO[31:0] : s0[31:0];
    fa1_10_r <= (s1 > I32_HI) ? I32_HI[31:0] : (s1 < I32_LO) ? I32_LO[31:0] : s1[31:0];
    dfb_11_r <= 33'(fa1_10_r) - 33'(fa0_10_r);
    fa0_11_r <= fa0_10_r;
    mb_12_r  <= wb_r[11] * dfb_11_r;
    fa0_12_r <= fa0_11_r;
    fab_13_r <= fsum[49:0];
  end

  bti_exp u_exp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl_i        (ctl_r[13]),
    .x_i          (fab_13_r),
    .out_strobe_r (out_strobe),
    .out_item_r   (out_item)
  );

endmodule

/* rtl/core/bti_checker.sv */
module bti_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input bti_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input bti_pkg::out_item_t out_item
);

  import bti_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##BTI_LATENCY out_strobe)
    else $error("result missing after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##BTI_LATENCY !out_strobe)
    else $error("result without an item");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == OP_LOAD) |-> ##BTI_LATENCY
      (out_item.value == 48'd0 && !out_item.saturated && !out_item.clamped_low))
    else $error("load result not zero");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.saturated) |-> (out_item.value == OUT_MAX))
    else $error("saturated result not at max");

endmodule

bind bilinear_table_interp_exp bti_checker u_bti_checker (.*);
